### design/rmst_pkg.sv
package rmst_pkg;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 10;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 11;
  localparam int LVL_W   = 4;
  localparam int LEN_W   = POS_W + 1;
  localparam int S_TDATA_W = 56;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_BEYOND    = 2'd2,
    STAT_NOT_BUILT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_REPLY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_QCMP = 2'd1,
    BK_BRD  = 2'd2,
    BK_BWR  = 2'd3
  } back_state_e;

  typedef struct packed {
    op_e               op;
    status_e           status;
    logic [LVL_W-1:0]  level;
    logic [POS_W-1:0]  addr_a;
    logic [POS_W-1:0]  addr_b;
    logic [DATA_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/rmst_front.sv
module rmst_front import rmst_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int COUNT_W      = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [COUNT_W-1:0]   count_i,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [S_TDATA_W-1:0] s_data_i,
  input  logic [CMD_W-1:0]     s_user_i,
  input  q_stat_t              stat_i,
  output logic                 push_o,
  output q_entry_t             entry_o
);

  logic             ready_q, ready_d;
  logic             accept;
  cmd_e             cmd;
  logic [POS_W-1:0] left, right;
  logic [DATA_W-1:0] value;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] second;
  logic [LVL_W-1:0] k;

  assign s_ready_o = !stat_i.full;
  assign accept    = s_valid_i && s_ready_o;
  assign cmd       = cmd_e'(s_user_i);
  assign left      = s_data_i[POS_W-1:0];
  assign right     = s_data_i[2*POS_W-1:POS_W];
  assign value     = s_data_i[2*POS_W+DATA_W-1:2*POS_W];
  assign len       = {1'b0, right} - {1'b0, left} + LEN_W'(1);

  always_comb begin
    k = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (len[b]) k = LVL_W'(b);
    end
    if (32'(k) > LEVELS - 1) k = LVL_W'(LEVELS - 1);
  end

  assign second = {1'b0, right} + LEN_W'(1) - (LEN_W'(1) << k);

  always_comb begin
    ready_d        = ready_q;
    push_o         = 1'b0;
    entry_o.op     = OP_REPLY;
    entry_o.status = STAT_OK;
    entry_o.level  = k;
    entry_o.addr_a = left;
    entry_o.addr_b = second[POS_W-1:0];
    entry_o.value  = value;
    if (cfg_we_i) ready_d = 1'b0;
    if (accept) begin
      case (cmd)
        CMD_LOAD: begin
          if (32'(left) < MAX_ELEMENTS) begin
            push_o     = 1'b1;
            entry_o.op = OP_LOAD;
            ready_d    = 1'b0;
          end
        end
        CMD_BUILD: begin
          push_o     = 1'b1;
          entry_o.op = OP_BUILD;
          ready_d    = 1'b1;
        end
        CMD_QUERY: begin
          push_o = 1'b1;
          if (!ready_q) begin
            entry_o.status = STAT_NOT_BUILT;
          end else if (COUNT_W'(right) >= count_i) begin
            entry_o.status = STAT_BEYOND;
          end else if (left > right) begin
            entry_o.status = STAT_EMPTY;
          end else begin
            entry_o.op = OP_QUERY;
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= ready_d;
    end
  end

endmodule

### design/rmst_fifo.sv
module rmst_fifo import rmst_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t entry_o,
  output q_stat_t  stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  q_entry_t        slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == NW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + NW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= entry_i;
  end

endmodule

### design/rmst_back.sv
module rmst_back import rmst_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_WIDTH  = 32,
  parameter int COUNT_W      = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] count_i,
  input  q_entry_t           entry_i,
  input  q_stat_t            stat_i,
  output logic               pop_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [DATA_W-1:0]  m_data_o,
  output logic [STAT_W-1:0]  m_user_o
);

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int LW = $clog2(LEVELS);
  localparam int AW = $clog2(LEVELS * MAX_ELEMENTS);
  localparam int SW = ((COUNT_W > LEVELS) ? COUNT_W : LEVELS) + 1;

  function automatic logic [AW-1:0] addr_f(input logic [LW-1:0] lvl, input logic [IW-1:0] idx);
    return AW'(lvl) * AW'(MAX_ELEMENTS) + AW'(idx);
  endfunction

  logic [VALUE_WIDTH-1:0] table_q [LEVELS*MAX_ELEMENTS];
  logic [VALUE_WIDTH-1:0] rd_a_q, rd_b_q;
  logic [VALUE_WIDTH-1:0] min_val;

  back_state_e            state_q, state_d;
  logic [LW-1:0]          lvl_q, lvl_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      out_min_q, out_min_d;
  status_e                out_status_q, out_status_d;

  logic                   out_free;
  logic                   mem_we, rd_en;
  logic [AW-1:0]          mem_wa, ra, rb;
  logic [VALUE_WIDTH-1:0] mem_wd;
  logic [SW-1:0]          len, cnt;

  assign min_val   = ($signed(rd_a_q) <= $signed(rd_b_q)) ? rd_a_q : rd_b_q;
  assign out_free  = !out_valid_q || m_ready_i;
  assign len       = SW'(1) << lvl_q;
  assign cnt       = SW'(count_i);
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_min_q;
  assign m_user_o  = out_status_q;

  always_comb begin
    state_d      = state_q;
    lvl_d        = lvl_q;
    idx_d        = idx_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    rd_en        = 1'b0;
    ra           = '0;
    rb           = '0;
    out_valid_d  = out_valid_q && !m_ready_i;
    out_min_d    = out_min_q;
    out_status_d = out_status_q;
    case (state_q)
      BK_IDLE: begin
        if (!stat_i.empty) begin
          case (entry_i.op)
            OP_LOAD: begin
              pop_o  = 1'b1;
              mem_we = 1'b1;
              mem_wa = addr_f(LW'(0), IW'(entry_i.addr_a));
              mem_wd = VALUE_WIDTH'($signed(entry_i.value));
            end
            OP_REPLY: begin
              if (out_free) begin
                pop_o        = 1'b1;
                out_valid_d  = 1'b1;
                out_min_d    = '0;
                out_status_d = entry_i.status;
              end
            end
            OP_QUERY: begin
              pop_o   = 1'b1;
              rd_en   = 1'b1;
              ra      = addr_f(LW'(entry_i.level), IW'(entry_i.addr_a));
              rb      = addr_f(LW'(entry_i.level), IW'(entry_i.addr_b));
              state_d = BK_QCMP;
            end
            OP_BUILD: begin
              pop_o = 1'b1;
              lvl_d = LW'(1);
              idx_d = '0;
              if (SW'(2) <= cnt) state_d = BK_BRD;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_QCMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_min_d    = DATA_W'($signed(min_val));
          out_status_d = STAT_OK;
          state_d      = BK_IDLE;
        end
      end
      BK_BRD: begin
        rd_en   = 1'b1;
        ra      = addr_f(lvl_q - LW'(1), idx_q);
        rb      = addr_f(lvl_q - LW'(1), IW'(SW'(idx_q) + (len >> 1)));
        state_d = BK_BWR;
      end
      BK_BWR: begin
        mem_we = 1'b1;
        mem_wa = addr_f(lvl_q, idx_q);
        mem_wd = min_val;
        if (SW'(idx_q) + SW'(1) + len <= cnt) begin
          idx_d   = idx_q + IW'(1);
          state_d = BK_BRD;
        end else if ((SW'(lvl_q) + SW'(1) < SW'(LEVELS)) && ((len << 1) <= cnt)) begin
          lvl_d   = lvl_q + LW'(1);
          idx_d   = '0;
          state_d = BK_BRD;
        end else begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      lvl_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_min_q    <= out_min_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) table_q[mem_wa] <= mem_wd;
    if (rd_en) begin
      rd_a_q <= table_q[ra];
      rd_b_q <= table_q[rb];
    end
  end

endmodule

### design/range_minimum_sparse_table.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: position, right_end, element_value
//                                              tuser: command
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: minimum; tuser: status
// cfg       in   cfg_we_i                      cfg_wdata_i: element_count
//
// A query is classified into the queue, then reads the two table read ports, then compares
// the pair into the output register once that register is free.
// A load writes one level-0 entry. A build writes each table entry by reading its pair, then
// writing on the single write port.
// Reset clears control state only; the table holds nothing defined until loaded and built.
// A full queue drops s_axis_tready; a held result stalls the back end only at the next output.
module range_minimum_sparse_table import rmst_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11,
  parameter int VALUE_WIDTH  = 32,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // position, right_end, element_value, zero pad
  input  logic [CMD_W-1:0]     s_axis_tuser,   // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // minimum
  output logic [STAT_W-1:0]    m_axis_tuser    // status
);

  localparam int COUNT_W = ($clog2(MAX_ELEMENTS + 1) > CFG_W) ?
                           $clog2(MAX_ELEMENTS + 1) : CFG_W;

  logic [CFG_W-1:0]   element_count_q;
  logic [COUNT_W-1:0] count;
  logic               push, pop;
  q_entry_t           push_entry, head_entry;
  q_stat_t            q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      element_count_q <= cfg_wdata_i;
    end
  end

  assign count = (COUNT_W'(element_count_q) > COUNT_W'(MAX_ELEMENTS)) ?
                 COUNT_W'(MAX_ELEMENTS) : COUNT_W'(element_count_q);

  rmst_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .COUNT_W      (COUNT_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .count_i   (count),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .stat_i    (q_stat),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  rmst_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  rmst_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .COUNT_W      (COUNT_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .count_i   (count),
    .entry_i   (head_entry),
    .stat_i    (q_stat),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue pushed while full");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0)
    else $error("error result carries a nonzero minimum");

endmodule

### sim/tb_top.sv
module tb_top;
  import rmst_pkg::*;

  localparam int unsigned MAX_ELEMS   = 1024;
  localparam int unsigned NUM_LEVELS  = 11;
  localparam int unsigned STALL_LIMIT = 250000;

  typedef struct packed {
    cmd_e              cmd;
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  right;
    logic [DATA_W-1:0] value;
  } rmq_request_t;

  typedef struct packed {
    logic [DATA_W-1:0] minimum;
    status_e           status;
  } rmq_answer_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // position, right_end, element_value, zero pad
  logic [CMD_W-1:0]     s_axis_tuser = '0;   // command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;        // minimum
  logic [STAT_W-1:0]    m_axis_tuser;        // status

  range_minimum_sparse_table #(
    .MAX_ELEMENTS(MAX_ELEMS),
    .LEVELS      (NUM_LEVELS),
    .VALUE_WIDTH (DATA_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus side
  rmq_request_t      request_fifo[$];
  rmq_answer_t       expected_answers[$];
  int unsigned       requests_queued = 0;
  int unsigned       requests_taken = 0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       receiver_stall_pct = 0;
  bit                item_taken = 1'b0;
  bit                was_loaded [MAX_ELEMS];
  int unsigned       stim_n = MAX_ELEMS;
  int unsigned       settings_used = 0;

  // predictor state
  logic signed [DATA_W-1:0] sparse_lvl [NUM_LEVELS][MAX_ELEMS];
  logic [CFG_W-1:0]         model_count = CFG_RESET;
  bit                       model_ready = 1'b0;

  // checker state
  int unsigned mismatches = 0;
  int unsigned answers_by_status [4];
  int unsigned idle_cycles = 0;
  bit          s_fire;
  bit          m_fire;

  function automatic logic signed [DATA_W-1:0] smaller(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    return (a <= b) ? a : b;
  endfunction

  task automatic update_sparse_model(input rmq_request_t r);
    int unsigned n;
    int unsigned lvl;
    int unsigned half;
    int unsigned idx;
    int unsigned span;
    int unsigned second;
    rmq_answer_t ans;
    n = (model_count > MAX_ELEMS) ? MAX_ELEMS : model_count;
    case (r.cmd)
      CMD_LOAD: begin
        sparse_lvl[0][r.left] = r.value;
        model_ready = 1'b0;
      end
      CMD_BUILD: begin
        for (lvl = 1; lvl < NUM_LEVELS && (1 << lvl) <= n; lvl++) begin
          half = 1 << (lvl - 1);
          for (idx = 0; idx + 2 * half <= n; idx++) begin
            sparse_lvl[lvl][idx] = smaller(sparse_lvl[lvl-1][idx], sparse_lvl[lvl-1][idx+half]);
          end
        end
        model_ready = 1'b1;
      end
      CMD_QUERY: begin
        ans.minimum = '0;
        if (!model_ready) begin
          ans.status = STAT_NOT_BUILT;
        end else if (r.right >= n) begin
          ans.status = STAT_BEYOND;
        end else if (r.left > r.right) begin
          ans.status = STAT_EMPTY;
        end else begin
          span = r.right - r.left + 1;
          lvl = 0;
          while ((2 << lvl) <= span) lvl++;
          second = r.right + 1 - (1 << lvl);
          ans.minimum = smaller(sparse_lvl[lvl][r.left], sparse_lvl[lvl][second]);
          ans.status = STAT_OK;
        end
        expected_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endtask

  // driver: present the next request at the falling edge
  always @(negedge clk_i) begin
    rmq_request_t r;
    if (rst_ni) begin
      if (!s_axis_tvalid || item_taken) begin
        item_taken = 1'b0;
        if (request_fifo.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          r = request_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, r.value, r.right, r.left};
          s_axis_tuser  <= r.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // monitor: predict accepted requests, check answers, watch for a hang
  always @(posedge clk_i) begin
    rmq_request_t r;
    rmq_answer_t  want;
    if (rst_ni) begin
      s_fire = s_axis_tvalid && s_axis_tready;
      m_fire = m_axis_tvalid && m_axis_tready;
      if (cfg_we_i) begin
        model_count = cfg_wdata_i;
        model_ready = 1'b0;
      end
      if (s_fire) begin
        r.cmd   = cmd_e'(s_axis_tuser);
        r.left  = s_axis_tdata[POS_W-1:0];
        r.right = s_axis_tdata[2*POS_W-1:POS_W];
        r.value = s_axis_tdata[2*POS_W+DATA_W-1:2*POS_W];
        update_sparse_model(r);
        requests_taken++;
        item_taken = 1'b1;
      end
      if (m_fire) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected answer: minimum %0d status %0d", $signed(m_axis_tdata),
                 m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          answers_by_status[want.status]++;
          if (m_axis_tdata !== want.minimum) begin
            $error("minimum: expected %0d, got %0d", $signed(want.minimum),
                   $signed(m_axis_tdata));
            mismatches++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (s_fire || m_fire || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_item(input cmd_e c, input int unsigned left, input int unsigned right,
                           input logic [DATA_W-1:0] v);
    rmq_request_t r;
    r.cmd   = c;
    r.left  = POS_W'(left);
    r.right = POS_W'(right);
    r.value = v;
    if (c == CMD_LOAD) was_loaded[r.left] = 1'b1;
    request_fifo.push_back(r);
    requests_queued++;
  endtask

  function automatic logic [DATA_W-1:0] pick_element();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(7));
      3: return {29'h1FFF_FFFF, 3'($urandom_range(7))};
      default: return $urandom();
    endcase
  endfunction

  task automatic push_random_query(input int unsigned n);
    int unsigned pick;
    int unsigned left;
    int unsigned right;
    pick = $urandom_range(99);
    if (n < MAX_ELEMS && (n == 0 || pick < 8)) begin
      left  = $urandom_range(MAX_ELEMS - 1);
      right = $urandom_range(MAX_ELEMS - 1, n);
    end else if (pick < 16 && n > 1) begin
      left  = $urandom_range(n - 1, 1);
      right = $urandom_range(left - 1, 0);
    end else if (pick < 26) begin
      left  = 0;
      right = n - 1;
    end else if (pick < 55) begin
      left  = $urandom_range(n - 1);
      right = left + $urandom_range(3);
      if (right > n - 1) right = n - 1;
    end else begin
      left  = $urandom_range(n - 1);
      right = $urandom_range(n - 1, left);
    end
    push_item(CMD_QUERY, left, right, $urandom());
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (requests_taken != requests_queued || expected_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_element_count(input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    stim_n = (v > MAX_ELEMS) ? MAX_ELEMS : v;
    settings_used++;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
      3: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
      default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] count_value, input int unsigned mode,
                           input int unsigned queries);
    int unsigned p;
    int unsigned q;
    int unsigned roll;
    set_idling(mode);
    write_element_count(count_value);
    for (p = 0; p < stim_n; p++) begin
      if (!was_loaded[p]) push_item(CMD_LOAD, p, $urandom_range(MAX_ELEMS - 1), pick_element());
    end
    for (p = 0; p < 4; p++) begin
      push_item(CMD_LOAD, $urandom_range(MAX_ELEMS - 1), $urandom_range(MAX_ELEMS - 1),
                pick_element());
    end
    push_random_query(stim_n);
    push_item(CMD_BUILD, $urandom_range(MAX_ELEMS - 1), $urandom_range(MAX_ELEMS - 1),
              $urandom());
    for (q = 0; q < queries; q++) begin
      if (q == queries / 2) wait_idle();
      roll = $urandom_range(99);
      if (roll < 3) begin
        push_item(CMD_NOP, $urandom_range(MAX_ELEMS - 1), $urandom_range(MAX_ELEMS - 1),
                  $urandom());
      end else if (roll < 6) begin
        push_item(CMD_LOAD, $urandom_range(MAX_ELEMS - 1), $urandom_range(MAX_ELEMS - 1),
                  pick_element());
        push_random_query(stim_n);
        push_item(CMD_BUILD, 0, 0, '0);
      end else begin
        push_random_query(stim_n);
      end
    end
    push_random_query(stim_n);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_element_count(11'd8);
    push_item(CMD_QUERY, 0, 0, '0);
    push_item(CMD_LOAD, 0, 0, 32'h7FFF_FFFF);
    push_item(CMD_LOAD, 1, 0, 32'h8000_0000);
    push_item(CMD_LOAD, 2, 0, 32'h0000_0000);
    push_item(CMD_LOAD, 3, 0, 32'hFFFF_FFFF);
    push_item(CMD_LOAD, 4, 0, 32'd5);
    push_item(CMD_LOAD, 5, 0, 32'hFFFF_FFFB);
    push_item(CMD_LOAD, 6, 0, 32'd123456);
    push_item(CMD_LOAD, 7, 0, 32'h8000_0001);
    push_item(CMD_BUILD, 0, 0, '0);
    push_item(CMD_QUERY, 0, 7, '0);
    push_item(CMD_QUERY, 3, 3, '0);
    push_item(CMD_QUERY, 2, 5, '0);
    push_item(CMD_QUERY, 7, 0, '0);
    push_item(CMD_QUERY, 0, 8, '0);
    push_item(CMD_QUERY, 1023, 9, '0);
    push_item(CMD_QUERY, 1023, 1023, '0);
    wait_idle();
    push_item(CMD_NOP, 1023, 1023, 32'hFFFF_FFFF);
    push_item(CMD_LOAD, 1023, 1023, 32'h1234_5678);
    push_item(CMD_QUERY, 9, 1023, '0);
    push_item(CMD_BUILD, 0, 0, '0);
    push_item(CMD_QUERY, 1, 6, '0);
    push_item(CMD_QUERY, 6, 7, '0);
    wait_idle();

    run_phase(11'd1,    0, 30);
    run_phase(11'd2,    1, 40);
    run_phase(11'd0,    2, 20);
    run_phase(11'd13,   3, 80);
    run_phase(11'd200,  0, 100);
    run_phase(11'd64,   1, 100);
    run_phase(11'd1024, 2, 40);
    run_phase(11'd2047, 3, 40);
    run_phase(11'd37,   0, 80);
    run_phase(11'd5,    1, 60);
    run_phase(11'd3,    2, 50);
    run_phase(11'd100,  3, 70);

    repeat (48) @(posedge clk_i);
    $display("Covered %0d transactions in over %0d element_count settings.",
             requests_taken, settings_used);
    $display("Answers: ok %0d, empty %0d, beyond count %0d, not built %0d.",
             answers_by_status[STAT_OK], answers_by_status[STAT_EMPTY],
             answers_by_status[STAT_BEYOND], answers_by_status[STAT_NOT_BUILT]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/rmst_pkg.sv
design/rmst_front.sv
design/rmst_fifo.sv
design/rmst_back.sv
design/range_minimum_sparse_table.sv
sim/tb_top.sv
